FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the character lookup shared by the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] UPPER_OFS = 8'd65;   // 'A'
    localparam logic [7:0] LOWER_OFS = 8'd71;   // 'a' - 26
    localparam logic [7:0] DIGIT_SUB = 8'd4;    // 52 - '0'
    localparam logic [7:0] PLUS_CHAR = 8'd43;   // '+'
    localparam logic [7:0] SLASH_CHAR = 8'd47;  // '/'
    localparam logic [7:0] PAD_CHAR = 8'd61;    // '='
    localparam int unsigned JOB_CHARS = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } b64e_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } b64e_out_t;

    // characters produced by one byte, emitted in order up to last_idx
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [1:0]                last_idx;
        logic                      last_flag;
    } b64e_job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] w;
        w = {2'b00, v};
        if (v <= 6'd25)
        begin
            c = w + UPPER_OFS;
        end
        else if (v <= 6'd51)
        begin
            c = w + LOWER_OFS;
        end
        else if (v <= 6'd61)
        begin
            c = w - DIGIT_SUB;
        end
        else if (v == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Byte-serial standard base64 encoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while full is low; each byte becomes a job
// of one character (first or second byte of a triple), two characters (third
// byte) or, on a final first or second byte, three or four characters
// including '=' padding, and out_last marks the final character. Characters
// leave at one per cycle while the consumer pops, from a single output
// register; the back end's one-character-per-cycle walk limits the byte
// rate, and the job queue (QDEPTH entries) lets bytes keep arriving meanwhile.
// The first character of a byte is written into the job queue and then into
// the result register before it is on the result ports and can be popped.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64e_pkg::b64e_in_t  in_item,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::b64e_out_t out_item
);
    import b64e_pkg::*;

    b64e_job_t wr_job, head_job;
    logic      job_wr, head_rd, q_empty;

    b64e_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .job_wr  (job_wr),
        .job     (wr_job)
    );

    b64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (wr_job),
        .full    (full),
        .rd_en   (head_rd),
        .rd_data (head_job),
        .empty   (q_empty)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .head_empty (q_empty),
        .head_rd    (head_rd),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule

FILE: hw/rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the triple phase and leftover bits, and
// turns each byte into a job of one to four characters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  b64e_pkg::b64e_in_t in_item,
    output logic               job_wr,
    output b64e_pkg::b64e_job_t job
);
    import b64e_pkg::*;

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;
    logic [7:0] b;
    logic       fin;

    assign accept = push && !full;
    assign job_wr = accept;
    assign b      = in_item.data_byte;
    assign fin    = in_item.final_byte;

    always_comb
    begin
        job        = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        unique case (phase_reg)
            PH1:
            begin
                job.chars[0] = sextet_char({left_reg[1:0], b[7:4]});
                if (fin)
                begin
                    job.chars[1]  = sextet_char({b[3:0], 2'b00});
                    job.chars[2]  = PAD_CHAR;
                    job.last_idx  = 2'd2;
                    job.last_flag = 1'b1;
                    phase_next    = PH0;
                    left_next     = 4'd0;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = PH2;
                    left_next    = b[3:0];
                end
            end
            PH2:
            begin
                job.chars[0]  = sextet_char({left_reg, b[7:6]});
                job.chars[1]  = sextet_char(b[5:0]);
                job.last_idx  = 2'd1;
                job.last_flag = fin;
                phase_next    = PH0;
                left_next     = 4'd0;
            end
            default:
            begin
                job.chars[0] = sextet_char(b[7:2]);
                if (fin)
                begin
                    job.chars[1]  = sextet_char({b[1:0], 4'b0000});
                    job.chars[2]  = PAD_CHAR;
                    job.chars[3]  = PAD_CHAR;
                    job.last_idx  = 2'd3;
                    job.last_flag = 1'b1;
                    phase_next    = PH0;
                    left_next     = 4'd0;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = PH1;
                    left_next    = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // a final byte always restarts the triple
    `ASSERT_NEXT(a_final_restarts, clk, rst_n, accept && fin, phase_reg == PH0 && left_reg == 4'd0)
    // leftover bits never exceed two bits after the first byte of a triple
    `ASSERT_ALWAYS(a_left_narrow, clk, rst_n, phase_reg != PH1 || left_reg[3:2] == 2'b00)

endmodule

FILE: hw/rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  b64e_pkg::b64e_job_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output b64e_pkg::b64e_job_t rd_data,
    output logic                empty
);
    import b64e_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64e_job_t         mem_reg [DEPTH];
    logic [AW-1:0]     wptr_reg, rptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wrap_inc(wptr_reg);
            end
            if (do_rd)
            begin
                rptr_reg <= wrap_inc(rptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    // pointers meet exactly when the queue is empty or full
    `ASSERT_ALWAYS(a_ptr_match, clk, rst_n, (wptr_reg == rptr_reg) == (empty || full))

endmodule

FILE: hw/rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle into the result register while it is empty or popped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64e_pkg::b64e_job_t head,
    input  logic                head_empty,
    output logic                head_rd,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::b64e_out_t out_item
);
    import b64e_pkg::*;

    logic       valid_reg;
    b64e_out_t  data_reg;
    logic [1:0] idx_reg;
    logic       adv;
    logic       take;
    logic       at_end;

    assign empty    = !valid_reg;
    assign out_item = data_reg;
    assign adv      = !valid_reg || pop;
    assign take     = adv && !head_empty;
    assign at_end   = (idx_reg == head.last_idx);
    assign head_rd  = take && at_end;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.out_char <= head.chars[idx_reg];
            data_reg.out_last <= head.last_flag && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= !head_empty;
            end
            if (take)
            begin
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    // the character index never runs past the head job
    `ASSERT_ALWAYS(a_idx_in_job, clk, rst_n, head_empty || idx_reg <= head.last_idx)
    // an index in the middle of a job means that job is still queued
    `ASSERT_ALWAYS(a_idx_held, clk, rst_n, idx_reg == 2'd0 || !head_empty)

endmodule
